// ===== design/erwc_pkg.sv =====
// ----------------------------------------------------------------------------
// erwc_pkg
// Shared types and constants for the edge rate window counter.
// ----------------------------------------------------------------------------
package erwc_pkg;

    localparam int unsigned ACT_W  = 2;
    localparam int unsigned TS_W   = 32;
    localparam int unsigned WIN_W  = 16;
    localparam int unsigned RATE_W = 5;

    localparam logic [ACT_W-1:0] ACT_EDGE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [TS_W-1:0]  timestamp;
    } t_in_item;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] peak_rate;
    } t_out_item;

endpackage

// ===== design/edge_rate_window_counter.sv =====
// ----------------------------------------------------------------------------
// edge_rate_window_counter
// Sliding-window event rate counter over a ring of recent edge stamps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one item per
//   beat: record edge, query rate or clear. Output channel (o_out_valid /
//   i_out_stall / o_out_data) returns rate and peak for each query only.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes window_ms;
//   write it only while the block is idle.
// Timing:
//   Edge, clear and unused codes are taken without stalling the input. A
//   query walks the filled stamp entries through the single read port of the
//   stamp store, one entry per cycle. Its count is registered as the rate,
//   the block waits in a hold state until the output register is free, and
//   the result is then loaded there; the next item is taken once idle again.
//   o_in_stall stays high while a query is in progress.
// Reset:
//   Synchronous, active low. Head, fill count and peak clear, window_ms
//   returns to 1000. The stamp store is not swept: only entries below the
//   fill count are ever read.
// Back-pressure:
//   The result sits in an output register; new items are taken while it waits.
//   A query finishing while that register is still held waits for it to drain.
// ----------------------------------------------------------------------------
module edge_rate_window_counter #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  erwc_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output erwc_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [erwc_pkg::WIN_W-1:0]   i_cfg_data
);

    localparam int unsigned HEAD_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [HEAD_W-1:0]          r_head;
    logic [CNT_W-1:0]           r_fill;
    logic [CNT_W-1:0]           r_peak;
    logic [CNT_W-1:0]           r_rate;
    logic [erwc_pkg::WIN_W-1:0] r_window;
    logic                       r_out_vld;
    erwc_pkg::t_out_item        r_out;

    logic                       in_acc;
    logic                       is_edge;
    logic                       is_query;
    logic                       is_clear;
    logic                       scan_done;
    logic [CNT_W-1:0]           scan_rate;
    logic                       out_free;
    logic                       load_out;
    logic [CNT_W-1:0]           peak_next;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign is_edge     = in_acc && (i_in_data.action == erwc_pkg::ACT_EDGE);
    assign is_query    = in_acc && (i_in_data.action == erwc_pkg::ACT_QUERY);
    assign is_clear    = in_acc && (i_in_data.action == erwc_pkg::ACT_CLEAR);
    assign out_free    = !r_out_vld || !i_out_stall;
    assign load_out    = (r_state == S_HOLD) && out_free;
    assign peak_next   = (r_rate > r_peak) ? r_rate : r_peak;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    erwc_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (is_edge),
        .i_wr_addr (r_head),
        .i_wr_data (i_in_data.timestamp),
        .i_start   (is_query),
        .i_now     (i_in_data.timestamp),
        .i_window  (r_window),
        .i_fill    (r_fill),
        .o_done    (scan_done),
        .o_rate    (scan_rate)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (is_query) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_fill    <= '0;
            r_peak    <= '0;
            r_window  <= erwc_pkg::WINDOW_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_data;
            end
            if (is_edge) begin
                r_head <= (r_head == HEAD_W'(CAPACITY - 1)) ? '0 : r_head + HEAD_W'(1);
                if (r_fill != CNT_W'(CAPACITY)) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (is_clear) begin
                r_head <= '0;
                r_fill <= '0;
                r_peak <= '0;
            end
            if (load_out) begin
                r_peak    <= peak_next;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && scan_done) begin
            r_rate <= scan_rate;
        end
        if (load_out) begin
            r_out.rate      <= erwc_pkg::RATE_W'(r_rate);
            r_out.peak_rate <= erwc_pkg::RATE_W'(peak_next);
        end
    end

endmodule

// ===== design/erwc_scan.sv =====
// ----------------------------------------------------------------------------
// erwc_scan
// Stamp store with one write port and a registered read port, plus the
// sequencer that walks the filled entries and counts those inside the window.
// ----------------------------------------------------------------------------
module erwc_scan #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0]          i_wr_addr,
    input  logic [erwc_pkg::TS_W-1:0]            i_wr_data,
    input  logic                                 i_start,
    input  logic [erwc_pkg::TS_W-1:0]            i_now,
    input  logic [erwc_pkg::WIN_W-1:0]           i_window,
    input  logic [$clog2(CAPACITY+1)-1:0]        i_fill,
    output logic                                 o_done,
    output logic [$clog2(CAPACITY+1)-1:0]        o_rate
);

    localparam int unsigned HEAD_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

    logic [erwc_pkg::TS_W-1:0] r_mem [CAPACITY];
    logic [erwc_pkg::TS_W-1:0] r_rd_data;
    logic [erwc_pkg::TS_W-1:0] r_now;
    logic [CNT_W-1:0]          r_idx;
    logic [CNT_W-1:0]          r_fill;
    logic [CNT_W-1:0]          r_rate;
    logic                      r_busy;
    logic                      r_eval;

    logic                      issue;
    logic                      hit;
    logic [erwc_pkg::TS_W-1:0] age;

    assign issue  = r_busy && (r_idx < r_fill);
    assign age    = r_now - r_rd_data;
    // stamps later than now are skipped; window is open at the far end
    assign hit    = (r_now >= r_rd_data) && (age < erwc_pkg::TS_W'(i_window));
    assign o_done = r_busy && !r_eval && !issue;
    assign o_rate = r_rate;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_idx[HEAD_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_now  <= i_now;
            r_fill <= i_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_eval <= 1'b0;
            r_idx  <= '0;
            r_rate <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_eval <= 1'b0;
            r_idx  <= '0;
            r_rate <= '0;
        end else begin
            r_eval <= issue;
            if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (r_eval && hit) begin
                r_rate <= r_rate + CNT_W'(1);
            end
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// ===== design/erwc_checker.sv =====
// ----------------------------------------------------------------------------
// erwc_checker
// Port-level checks for the edge rate window counter, bound to the top level.
// ----------------------------------------------------------------------------
module erwc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  erwc_pkg::t_in_item           i_in_data,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  erwc_pkg::t_out_item          o_out_data
);

    logic in_beat;

    assign in_beat = i_in_valid && !o_in_stall;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_rate_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.rate <= o_out_data.peak_rate))
        else $error("rate above peak");

    // a query occupies the block for at least the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_in_data.action == erwc_pkg::ACT_QUERY) |=> o_in_stall)
        else $error("query did not hold off input");

    // edge, clear and unused codes leave the input free in the following cycle
    a_short_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_in_data.action != erwc_pkg::ACT_QUERY) |=> !o_in_stall)
        else $error("non-query beat stalled input");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind edge_rate_window_counter erwc_checker u_erwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
